// ----- design/slx_pkg.sv -----
// ----------------------------------------------------------------------------
// slx_pkg
// Shared types, token codes and helpers for the script lexer.
// ----------------------------------------------------------------------------
package slx_pkg;

  localparam int PosBits      = 16;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);
  localparam int QueueCntBits = $clog2(QueueDepth + 1);

  typedef logic [PosBits-1:0] pos_t;

  localparam logic [30:0] NumMax = 31'h7FFF_FFFF;

  // identifier hashes, h = h*10 + (c - '0') wrapping at 32 bits
  localparam logic [31:0] HashPrintPointer = 32'hAAA8_6504;
  localparam logic [31:0] HashFi           = 32'd597;
  localparam logic [31:0] HashIf           = 32'd624;
  localparam logic [31:0] HashVal          = 32'd3998;
  localparam logic [31:0] HashElif         = 32'd59624;
  localparam logic [31:0] HashElse         = 32'd59723;
  localparam logic [31:0] HashFunc1        = 32'd615711;
  localparam logic [31:0] HashFunc2        = 32'd615712;
  localparam logic [31:0] HashFunc3        = 32'd615713;

  typedef enum logic [4:0] {
    TOK_END       = 5'd0,
    TOK_NUMBER    = 5'd1,
    TOK_STRING    = 5'd2,
    TOK_UNKNOWN   = 5'd3,
    TOK_IF        = 5'd4,
    TOK_ELSE      = 5'd5,
    TOK_FI        = 5'd6,
    TOK_VAL       = 5'd7,
    TOK_LPAREN    = 5'd8,
    TOK_RPAREN    = 5'd9,
    TOK_COMMA     = 5'd10,
    TOK_SEMI      = 5'd11,
    TOK_LT        = 5'd12,
    TOK_LE        = 5'd13,
    TOK_GT        = 5'd14,
    TOK_GE        = 5'd15,
    TOK_ASSIGN    = 5'd16,
    TOK_EQUAL     = 5'd17,
    TOK_AND       = 5'd18,
    TOK_LAND      = 5'd19,
    TOK_OR        = 5'd20,
    TOK_LOR       = 5'd21,
    TOK_FUNC1     = 5'd22,
    TOK_FUNC2     = 5'd23,
    TOK_FUNC3     = 5'd24,
    TOK_PRINTPTR  = 5'd25,
    TOK_BAD_CHAR  = 5'd26,
    TOK_OPEN_STR  = 5'd27
  } tok_code_e;

  typedef struct packed {
    tok_code_e   code;
    logic [30:0] value;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic        last;
  } token_t;

  // tokens produced by one text byte
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } tok_pair_t;

  function automatic tok_code_e classify(input logic [31:0] h);
    tok_code_e r;
    case (h)
      HashIf, HashElif: r = TOK_IF;
      HashElse:         r = TOK_ELSE;
      HashFi:           r = TOK_FI;
      HashVal:          r = TOK_VAL;
      HashFunc1:        r = TOK_FUNC1;
      HashFunc2:        r = TOK_FUNC2;
      HashFunc3:        r = TOK_FUNC3;
      HashPrintPointer: r = TOK_PRINTPTR;
      default:          r = TOK_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic token_t make_tok(input tok_code_e code, input logic [30:0] value,
                                      input pos_t start, input pos_t len,
                                      input logic [15:0] line);
    token_t      t;
    logic [31:0] ws;
    logic [31:0] wl;
    ws       = 32'(start);
    wl       = 32'(len);
    t.code   = code;
    t.value  = value;
    t.start  = ws[15:0];
    t.length = (wl > 32'd65535) ? 16'hFFFF : wl[15:0];
    t.line   = line;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

// ----- design/slx_scan.sv -----
// ----------------------------------------------------------------------------
// slx_scan
// Front end: scans one text byte per cycle while accept_i is high, keeps the token state and
// produces the zero, one or two tokens that the byte completes.
// ----------------------------------------------------------------------------
module slx_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  output logic              push_o,
  output slx_pkg::tok_pair_t pair_o
);

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_NUM   = 4'd1,
    M_IDENT = 4'd2,
    M_STR   = 4'd3,
    M_LT    = 4'd4,
    M_GT    = 4'd5,
    M_EQ    = 4'd6,
    M_AMP   = 4'd7,
    M_BAR   = 4'd8
  } mode_e;

  localparam logic [7:0] ChNul   = 8'd0;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChQuote = 8'd34;
  localparam logic [7:0] ChAmp   = 8'd38;
  localparam logic [7:0] ChLpar  = 8'd40;
  localparam logic [7:0] ChRpar  = 8'd41;
  localparam logic [7:0] ChComma = 8'd44;
  localparam logic [7:0] ChSemi  = 8'd59;
  localparam logic [7:0] ChLt    = 8'd60;
  localparam logic [7:0] ChEq    = 8'd61;
  localparam logic [7:0] ChGt    = 8'd62;
  localparam logic [7:0] ChBar   = 8'd124;

  mode_e          mode_q, mode_d;
  logic [31:0]    acc_q, acc_d;
  slx_pkg::pos_t  start_q, start_d;
  slx_pkg::pos_t  pos_q, pos_d;
  logic [15:0]    line_q, line_d;

  logic               is_dig, is_let, is_op, done;
  logic               pend_v, fresh_v;
  slx_pkg::token_t    pend_tok, fresh_tok;
  slx_pkg::pos_t      nxt, span;
  logic [35:0]        mac;
  logic [31:0]        num_next;
  logic [7:0]         op_second;
  slx_pkg::tok_code_e op_one, op_two;

  always_comb begin
    is_dig   = (byte_i >= 8'd48) && (byte_i <= 8'd57);
    is_let   = ((byte_i >= 8'd65) && (byte_i <= 8'd90)) ||
               ((byte_i >= 8'd97) && (byte_i <= 8'd122));
    nxt      = pos_q + slx_pkg::pos_t'(1);
    span     = pos_q - start_q;
    // shared multiply-by-ten; only used for digits and letters (c >= '0')
    mac      = 36'(acc_q) * 36'd10 + 36'(byte_i) - 36'd48;
    num_next = (mac > 36'(slx_pkg::NumMax)) ? {1'b0, slx_pkg::NumMax} : mac[31:0];

    mode_d  = mode_q;
    acc_d   = acc_q;
    start_d = start_q;
    pos_d   = pos_q;
    line_d  = line_q;

    pend_v    = 1'b0;
    fresh_v   = 1'b0;
    pend_tok  = slx_pkg::make_tok(slx_pkg::TOK_END, '0, start_q, '0, line_q);
    fresh_tok = slx_pkg::make_tok(slx_pkg::TOK_END, '0, pos_q, '0, line_q);
    done      = 1'b0;
    is_op     = 1'b0;
    op_second = ChEq;
    op_one    = slx_pkg::TOK_LT;
    op_two    = slx_pkg::TOK_LE;

    case (mode_q)
      M_NUM: begin
        if (is_dig) begin
          acc_d = num_next;
          pos_d = nxt;
          done  = 1'b1;
        end else begin
          pend_v   = 1'b1;
          pend_tok = slx_pkg::make_tok(slx_pkg::TOK_NUMBER, acc_q[30:0], start_q, span,
                                       line_q);
          mode_d   = M_IDLE;
        end
      end
      M_IDENT: begin
        if (is_dig || is_let) begin
          acc_d = mac[31:0];
          pos_d = nxt;
          done  = 1'b1;
        end else begin
          pend_v   = 1'b1;
          pend_tok = slx_pkg::make_tok(slx_pkg::classify(acc_q), '0, start_q, span, line_q);
          mode_d   = M_IDLE;
        end
      end
      M_STR: begin
        if (byte_i == ChQuote) begin
          pend_v   = 1'b1;
          pend_tok = slx_pkg::make_tok(slx_pkg::TOK_STRING, '0, start_q, span, line_q);
          mode_d   = M_IDLE;
          pos_d    = nxt;
          done     = 1'b1;
        end else if (byte_i != ChNul) begin
          pos_d = nxt;
          done  = 1'b1;
        end else begin
          pend_v   = 1'b1;
          pend_tok = slx_pkg::make_tok(slx_pkg::TOK_OPEN_STR, '0, start_q, span, line_q);
          mode_d   = M_IDLE;
        end
      end
      M_LT: begin
        is_op = 1'b1;
      end
      M_GT: begin
        is_op  = 1'b1;
        op_one = slx_pkg::TOK_GT;
        op_two = slx_pkg::TOK_GE;
      end
      M_EQ: begin
        is_op  = 1'b1;
        op_one = slx_pkg::TOK_ASSIGN;
        op_two = slx_pkg::TOK_EQUAL;
      end
      M_AMP: begin
        is_op     = 1'b1;
        op_second = ChAmp;
        op_one    = slx_pkg::TOK_AND;
        op_two    = slx_pkg::TOK_LAND;
      end
      M_BAR: begin
        is_op     = 1'b1;
        op_second = ChBar;
        op_one    = slx_pkg::TOK_OR;
        op_two    = slx_pkg::TOK_LOR;
      end
      default: mode_d = M_IDLE;
    endcase

    // pending operator: one byte of lookahead decides the two-char form
    if (is_op) begin
      pend_v = 1'b1;
      mode_d = M_IDLE;
      if (byte_i == op_second) begin
        pend_tok = slx_pkg::make_tok(op_two, '0, start_q, slx_pkg::pos_t'(2), line_q);
        pos_d    = nxt;
        done     = 1'b1;
      end else begin
        pend_tok = slx_pkg::make_tok(op_one, '0, start_q, slx_pkg::pos_t'(1), line_q);
      end
    end

    if (!done) begin
      if (byte_i == ChNul) begin
        fresh_v   = 1'b1;
        fresh_tok = slx_pkg::make_tok(slx_pkg::TOK_END, '0, pos_q, '0, line_q);
        mode_d    = M_IDLE;
        acc_d     = '0;
        start_d   = '0;
        pos_d     = '0;
        line_d    = 16'd1;
      end else begin
        pos_d = nxt;
        if (is_dig) begin
          mode_d  = M_NUM;
          start_d = pos_q;
          acc_d   = 32'(byte_i) - 32'd48;
        end else if (is_let) begin
          mode_d  = M_IDENT;
          start_d = pos_q;
          acc_d   = 32'(byte_i) - 32'd48;
        end else begin
          case (byte_i)
            ChQuote: begin
              mode_d  = M_STR;
              start_d = nxt;
            end
            ChLt: begin
              mode_d  = M_LT;
              start_d = pos_q;
            end
            ChGt: begin
              mode_d  = M_GT;
              start_d = pos_q;
            end
            ChEq: begin
              mode_d  = M_EQ;
              start_d = pos_q;
            end
            ChAmp: begin
              mode_d  = M_AMP;
              start_d = pos_q;
            end
            ChBar: begin
              mode_d  = M_BAR;
              start_d = pos_q;
            end
            ChLpar: begin
              fresh_v   = 1'b1;
              fresh_tok = slx_pkg::make_tok(slx_pkg::TOK_LPAREN, '0, pos_q,
                                            slx_pkg::pos_t'(1), line_q);
            end
            ChRpar: begin
              fresh_v   = 1'b1;
              fresh_tok = slx_pkg::make_tok(slx_pkg::TOK_RPAREN, '0, pos_q,
                                            slx_pkg::pos_t'(1), line_q);
            end
            ChComma: begin
              fresh_v   = 1'b1;
              fresh_tok = slx_pkg::make_tok(slx_pkg::TOK_COMMA, '0, pos_q,
                                            slx_pkg::pos_t'(1), line_q);
            end
            ChSemi: begin
              fresh_v   = 1'b1;
              fresh_tok = slx_pkg::make_tok(slx_pkg::TOK_SEMI, '0, pos_q,
                                            slx_pkg::pos_t'(1), line_q);
            end
            ChLf: begin
              if (line_q != 16'hFFFF) begin
                line_d = line_q + 16'd1;
              end
            end
            ChSpace, ChTab, ChCr: ;
            default: begin
              fresh_v   = 1'b1;
              fresh_tok = slx_pkg::make_tok(slx_pkg::TOK_BAD_CHAR, '0, pos_q,
                                            slx_pkg::pos_t'(1), line_q);
            end
          endcase
        end
      end
    end

    pair_o.two    = pend_v && fresh_v;
    pair_o.first  = pend_v ? pend_tok : fresh_tok;
    pair_o.second = fresh_tok;
    pair_o.first.last  = !(pend_v && fresh_v);
    pair_o.second.last = 1'b1;
    push_o = accept_i && (pend_v || fresh_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      acc_q   <= '0;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= 16'd1;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
    end
  end

endmodule

// ----- design/slx_queue.sv -----
// ----------------------------------------------------------------------------
// slx_queue
// Short FIFO of token pairs between the scanner and the output stage.
// ----------------------------------------------------------------------------
module slx_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  slx_pkg::tok_pair_t data_i,
  input  logic               pop_i,
  output slx_pkg::tok_pair_t data_o,
  output logic               empty_o,
  output logic               full_o
);

  slx_pkg::tok_pair_t                      entry_q [slx_pkg::QueueDepth];
  logic [slx_pkg::QueuePtrBits-1:0]        wr_q, rd_q;
  logic [slx_pkg::QueueCntBits-1:0]        cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == slx_pkg::QueueCntBits'(slx_pkg::QueueDepth));
  assign data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- design/slx_emit.sv -----
// ----------------------------------------------------------------------------
// slx_emit
// Back end: splits queued token pairs and drives the output register.
// ----------------------------------------------------------------------------
module slx_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slx_pkg::tok_pair_t head_i,
  input  logic               empty_i,
  output logic               pop_o,
  input  logic               stall_i,
  output logic               valid_o,
  output slx_pkg::token_t    token_o
);

  logic            valid_q;
  logic            sub_q;
  slx_pkg::token_t token_q;
  logic            load, take;

  assign load    = !valid_q || !stall_i;
  assign take    = load && !empty_i;
  assign pop_o   = take && (sub_q || !head_i.two);
  assign valid_o = valid_q;
  assign token_o = token_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 1'b0;
    end else if (load) begin
      valid_q <= take;
      if (take) begin
        sub_q <= !sub_q && head_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      token_q <= sub_q ? head_i.second : head_i.first;
    end
  end

endmodule

// ----- design/script_lexer.sv -----
// ----------------------------------------------------------------------------
// script_lexer
// Streaming tokenizer: scanner front end, token-pair queue, output stage.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle while the queue is not full; a byte
//   that finishes two tokens sends them out in turn, absorbed by the 4-entry pair queue.
// Path: a token is registered into the pair queue when the byte that
//   completes it is accepted, then into the output register.
// Reset: asynchronous; scanner state to idle, line 1, queue and output
//   emptied. No clearing pass.
module script_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        text_valid_i,
  output logic        text_stall_o,
  input  logic [7:0]  text_byte_i,
  output logic        token_valid_o,
  input  logic        token_stall_i,
  output logic [4:0]  token_code_o,
  output logic [30:0] number_value_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic [15:0] line_number_o,
  output logic        last_of_run_o
);

  logic               accept, push, pop, q_empty, q_full;
  slx_pkg::tok_pair_t pair, head;
  slx_pkg::token_t    tok;

  assign text_stall_o = q_full;
  assign accept       = text_valid_i && !q_full;

  slx_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (text_byte_i),
    .push_o   (push),
    .pair_o   (pair)
  );

  slx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (pair),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  slx_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .stall_i (token_stall_i),
    .valid_o (token_valid_o),
    .token_o (tok)
  );

  assign token_code_o   = tok.code;
  assign number_value_o = tok.value;
  assign token_start_o  = tok.start;
  assign token_length_o = tok.length;
  assign line_number_o  = tok.line;
  assign last_of_run_o  = tok.last;

  // end of text is always the final token of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_valid_o && (token_code_o == slx_pkg::TOK_END) |-> last_of_run_o)
    else $error("end token not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_valid_o && (token_code_o == slx_pkg::TOK_NUMBER) |-> (token_length_o != 16'd0))
    else $error("number token with zero length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_valid_o && (token_code_o != slx_pkg::TOK_NUMBER) |-> (number_value_o == 31'd0))
    else $error("value on non-number token");

  // queue never overruns: a push only happens on an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("push into full token queue");

endmodule
